[rtl/bfs_pkg.sv]
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared constants, types and helpers for the bucketed float sorter.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int NUM_BUCKETS = 41;

    localparam int VAL_W  = 32;
    localparam int BKEY_W = 8;
    localparam int KEY_W  = $clog2(NUM_BUCKETS);
    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ENT_W  = KEY_W + VAL_W;
    localparam int TUP_W  = KEY_W + VAL_W + IDX_W;

    // controller -> datapath
    typedef struct packed {
        logic load;        // write incoming transaction into the store
        logic pass_start;  // restart the minimum search
        logic rd;          // read next store entry
        logic emit_done;   // current result taken
        logic batch_clr;   // batch fully emitted
    } bfs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic store_full_next; // accepting now fills the store
        logic rd_at_end;       // read address is the last stored entry
        logic emit_last;       // current result is the last of the batch
    } bfs_stat_t;

    // order-preserving map of IEEE single bits to unsigned
    function automatic logic [VAL_W-1:0] ord_bits(input logic [VAL_W-1:0] b);
        ord_bits = b[VAL_W-1] ? ~b : (b ^ {1'b1, {(VAL_W-1){1'b0}}});
    endfunction

endpackage

[rtl/bfs_ctrl.sv]
// ----------------------------------------------------------------------------
// bfs_ctrl
// Sequencer: load, repeated minimum-search passes, one result per pass.
// ----------------------------------------------------------------------------
module bfs_ctrl import bfs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_last_item,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  bfs_stat_t stat,
    output bfs_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    logic load_acc;
    logic out_acc;

    assign load_acc = (state_reg == ST_LOAD) && s_valid && s_ready_reg;
    assign out_acc  = (state_reg == ST_EMIT) && m_valid_reg && m_ready;

    always_comb begin
        cmd            = '0;
        cmd.load       = load_acc;
        cmd.rd         = (state_reg == ST_SCAN);
        cmd.emit_done  = out_acc;
        cmd.batch_clr  = out_acc && stat.emit_last;
        cmd.pass_start = (load_acc && (s_last_item || stat.store_full_next)) ||
                         (out_acc && !stat.emit_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (load_acc && (s_last_item || stat.store_full_next)) begin
                        state_reg   <= ST_SCAN;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (stat.rd_at_end) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg   <= ST_EMIT;
                    m_valid_reg <= 1'b1;
                end
                ST_EMIT: begin
                    if (out_acc) begin
                        m_valid_reg <= 1'b0;
                        if (stat.emit_last) begin
                            state_reg   <= ST_LOAD;
                            s_ready_reg <= 1'b1;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    state_reg   <= ST_LOAD;
                    s_ready_reg <= 1'b1;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

[rtl/bfs_datapath.sv]
// ----------------------------------------------------------------------------
// bfs_datapath
// Item store, key clamp, and the tuple minimum search.
// ----------------------------------------------------------------------------
module bfs_datapath import bfs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [VAL_W-1:0]  s_value_bits,
    input  logic [BKEY_W-1:0] s_bucket_key,
    input  bfs_cmd_t          cmd,
    output bfs_stat_t         stat,
    output logic [VAL_W-1:0]  m_sorted_bits
);

    logic [ENT_W-1:0] mem [MAX_ITEMS];

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_idx_d_reg;
    logic             rd_vld_reg;
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] out_cnt_reg;
    logic [TUP_W-1:0] prev_reg;
    logic             prev_vld_reg;
    logic [TUP_W-1:0] best_reg;
    logic             best_vld_reg;
    logic [VAL_W-1:0] best_bits_reg;

    logic [KEY_W-1:0] key_clamped;
    logic [ENT_W-1:0] entry;
    logic [TUP_W-1:0] cand;
    logic             cand_take;

    // clamp signed key to 0..NUM_BUCKETS-1
    always_comb begin
        if (s_bucket_key[BKEY_W-1]) begin
            key_clamped = '0;
        end else if ($signed(s_bucket_key) > $signed(BKEY_W'(NUM_BUCKETS - 1))) begin
            key_clamped = KEY_W'(NUM_BUCKETS - 1);
        end else begin
            key_clamped = s_bucket_key[KEY_W-1:0];
        end
    end

    assign entry = {key_clamped, s_value_bits};

    // arrival index breaks ties, giving stable order
    assign cand = {rd_data_reg[ENT_W-1:VAL_W], ord_bits(rd_data_reg[VAL_W-1:0]),
                   rd_idx_d_reg};
    assign cand_take = rd_vld_reg && (!prev_vld_reg || (cand > prev_reg)) &&
                       (!best_vld_reg || (cand < best_reg));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[count_reg[IDX_W-1:0]] <= entry;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        rd_idx_d_reg <= rd_idx_reg;
        if (cmd.rd) begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
        end
        if (cmd.pass_start) begin
            rd_idx_reg <= '0;
        end
        if (cand_take) begin
            best_reg      <= cand;
            best_bits_reg <= rd_data_reg[VAL_W-1:0];
        end
        if (cmd.emit_done) begin
            prev_reg <= best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            out_cnt_reg  <= '0;
            prev_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd;
            if (cmd.load) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cand_take) begin
                best_vld_reg <= 1'b1;
            end
            if (cmd.pass_start) begin
                best_vld_reg <= 1'b0;
            end
            if (cmd.emit_done) begin
                prev_vld_reg <= 1'b1;
                out_cnt_reg  <= out_cnt_reg + 1'b1;
            end
            if (cmd.batch_clr) begin
                count_reg    <= '0;
                out_cnt_reg  <= '0;
                prev_vld_reg <= 1'b0;
                best_vld_reg <= 1'b0;
            end
        end
    end

    assign stat.store_full_next = (count_reg == CNT_W'(MAX_ITEMS - 1));
    assign stat.rd_at_end       = ((CNT_W'(rd_idx_reg) + 1'b1) == count_reg);
    assign stat.emit_last       = ((CNT_W'(out_cnt_reg) + 1'b1) == count_reg);

    assign m_sorted_bits = best_bits_reg;

endmodule

[rtl/bucketed_float_sorter_core.sv]
// ----------------------------------------------------------------------------
// bucketed_float_sorter_core
// Batch sorter: orders by clamped bucket key, then by float value.
// ----------------------------------------------------------------------------
// Loading: one transaction per cycle until last_item or a full store (64).
// Emission: one full pass over the store per result; each pass reads every
//   stored entry, drains the last read, then holds the result until m_ready.
// The store has a single read port, which sets the one-entry-per-cycle pass.
// Reset (aresetn low, synchronous) empties the batch and returns to loading.
// ----------------------------------------------------------------------------
module bucketed_float_sorter_core import bfs_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [VAL_W-1:0]  s_value_bits,
    input  logic [BKEY_W-1:0] s_bucket_key,
    input  logic              s_last_item,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [VAL_W-1:0]  m_sorted_bits,
    output logic              m_last_out
);

    // Each pass finds the smallest (key, ordered value, arrival index) tuple
    // strictly above the one emitted last; the arrival index keeps equal
    // elements in arrival order.
    bfs_cmd_t  cmd;
    bfs_stat_t stat;

    bfs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_item (s_last_item),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    bfs_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_value_bits  (s_value_bits),
        .s_bucket_key  (s_bucket_key),
        .cmd           (cmd),
        .stat          (stat),
        .m_sorted_bits (m_sorted_bits)
    );

    // final transaction of the batch
    assign m_last_out = stat.emit_last;

endmodule
